@@ rtl/ring_fourier_mode_analyzer_defines.svh @@
// Assertion macros shared by the ring Fourier mode analyser RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RING_FOURIER_MODE_ANALYZER_DEFINES_SVH
`define RING_FOURIER_MODE_ANALYZER_DEFINES_SVH
`ifndef SYNTH
`define RFMA_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfma: same-cycle check failed");
`define RFMA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfma: next-cycle check failed");
`else
`define RFMA_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define RFMA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rfma_pkg.sv @@
// Package for the ring Fourier mode analyser: widths, constants, CORDIC
// angle table and the structs passed between its modules. No dependencies.
package rfma_pkg;

    localparam int MAX_RING     = 1024;
    localparam int MAX_MODES    = 64;
    localparam int RING_AW      = $clog2(MAX_RING);
    localparam int LEN_W        = 11;
    localparam int MODE_W       = 6;
    localparam int SAMPLE_W     = 24;
    localparam int CORDIC_STEPS = 30;
    localparam int ROT_W        = 34;
    localparam int TW_W         = 26;
    localparam int PROD_W       = SAMPLE_W + TW_W;
    localparam int ACC_W        = 62;
    localparam int MAG_W        = ACC_W - 1;
    localparam int DIV_W        = 48;
    localparam int AMP_W        = 34;
    localparam int PHASE_W      = 16;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 56;

    localparam logic [ROT_W-1:0] ROT_GAIN = ROT_W'(652032874);
    localparam logic [21:0]      AMP_GAIN = 22'd4000824;
    localparam logic [AMP_W-1:0] AMP_MAX  = {AMP_W{1'b1}};

    localparam logic [LEN_W-1:0] RING_DEFAULT = 11'd256;
    localparam logic [MODE_W-1:0] MODE_DEFAULT = 6'd8;
    localparam logic [LEN_W-1:0] RING_MIN     = 11'd2;
    localparam logic [LEN_W-1:0] RING_MAX     = LEN_W'(MAX_RING);

    localparam logic REG_RING_LENGTH  = 1'b0;
    localparam logic REG_HIGHEST_MODE = 1'b1;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [31:0]                angle;
        logic signed [SAMPLE_W-1:0] sample;
    } t_tw_in;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [TW_W-1:0]     cosv;
        logic signed [TW_W-1:0]     sinv;
    } t_tw_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [LEN_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
        logic [31:0]      ang;
    } t_pol_rsp;

    // atan(2^-i) as a Q32 fraction of a turn
    function automatic logic [31:0] turn_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/rfma_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rfma_pkg (widths, request/response structs).
module rfma_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfma_pkg::t_div_req i_req,
    output rfma_pkg::t_div_rsp o_rsp
);
    import rfma_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [LEN_W-1:0] r_rem, r_d;
    logic [LEN_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_q[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign n_busy = i_req.start ? 1'b1 :
                    (r_busy && r_cnt == CNT_W'(DIV_W - 1)) ? 1'b0 : r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && r_cnt == CNT_W'(DIV_W - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? LEN_W'(trial - {1'b0, r_d}) : trial[LEN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

@@ rtl/rfma_twiddle.sv @@
// Pipelined rotation CORDIC: turns a Q32 turn angle into Q24 cos/sin,
// carrying the sample alongside. Depends on rfma_pkg.
module rfma_twiddle (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfma_pkg::t_tw_in  i_tw,
    output rfma_pkg::t_tw_out o_tw
);
    import rfma_pkg::*;

    logic signed [ROT_W-1:0]    r_x   [0:CORDIC_STEPS];
    logic signed [ROT_W-1:0]    r_y   [0:CORDIC_STEPS];
    logic signed [ROT_W-1:0]    r_z   [0:CORDIC_STEPS];
    logic [1:0]                 r_qd  [0:CORDIC_STEPS];
    logic signed [SAMPLE_W-1:0] r_smp [0:CORDIC_STEPS];
    logic                       r_lst [0:CORDIC_STEPS];
    logic                       r_v   [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_x[0]   <= ROT_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= ROT_W'(i_tw.angle[29:0]);
        r_qd[0]  <= i_tw.angle[31:30];
        r_smp[0] <= i_tw.sample;
        r_lst[0] <= i_tw.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else          r_v[0] <= i_tw.valid;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic signed [ROT_W-1:0] dx, dy, da;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign da = ROT_W'(turn_atan(5'(i)));

        always_ff @(posedge i_clk) begin
            if (!r_z[i][ROT_W-1]) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - da;
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + da;
            end
            r_qd[i+1]  <= r_qd[i];
            r_smp[i+1] <= r_smp[i];
            r_lst[i+1] <= r_lst[i];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else          r_v[i+1] <= r_v[i];
        end
    end

    // round Q30 to Q24, then fold in the quadrant
    logic signed [ROT_W-1:0] xs, ys;
    logic signed [TW_W-1:0]  xr, yr;
    assign xs = (r_x[CORDIC_STEPS] + ROT_W'(32)) >>> 6;
    assign ys = (r_y[CORDIC_STEPS] + ROT_W'(32)) >>> 6;
    assign xr = xs[TW_W-1:0];
    assign yr = ys[TW_W-1:0];

    t_tw_out r_out;

    always_ff @(posedge i_clk) begin
        r_out.last   <= r_lst[CORDIC_STEPS];
        r_out.sample <= r_smp[CORDIC_STEPS];
        case (r_qd[CORDIC_STEPS])
            2'd0:    begin r_out.cosv <= xr;  r_out.sinv <= yr;  end
            2'd1:    begin r_out.cosv <= -yr; r_out.sinv <= xr;  end
            2'd2:    begin r_out.cosv <= -xr; r_out.sinv <= -yr; end
            default: begin r_out.cosv <= yr;  r_out.sinv <= -xr; end
        endcase
        if (!i_rst_n) r_out.valid <= 1'b0;
        else          r_out.valid <= r_v[CORDIC_STEPS];
    end

    assign o_tw = r_out;

endmodule

@@ rtl/rfma_polar.sv @@
// Iterative vectoring CORDIC: (A,B) to magnitude and Q32 turn angle,
// one micro-rotation per cycle. Depends on rfma_pkg.
module rfma_polar (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [rfma_pkg::ACC_W-1:0] i_a,
    input  logic signed [rfma_pkg::ACC_W-1:0] i_b,
    output rfma_pkg::t_pol_rsp          o_rsp
);
    import rfma_pkg::*;

    logic                    r_busy, r_done, r_zero;
    logic [4:0]              r_i;
    logic signed [ACC_W-1:0] r_a, r_b;
    logic [31:0]             r_z;
    logic signed [ACC_W-1:0] dx, dy;
    logic                    last_it;

    assign dx = r_b >>> r_i;
    assign dy = r_a >>> r_i;
    assign last_it = r_i == 5'(CORDIC_STEPS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last_it;
            if (i_start)                r_busy <= 1'b1;
            else if (r_busy && last_it) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // left half-plane: rotate by half a turn first
            r_a    <= i_a[ACC_W-1] ? -i_a : i_a;
            r_b    <= i_a[ACC_W-1] ? -i_b : i_b;
            r_z    <= i_a[ACC_W-1] ? 32'h80000000 : 32'h0;
            r_zero <= (i_a == '0) && (i_b == '0);
            r_i    <= '0;
        end else if (r_busy) begin
            if (!r_b[ACC_W-1]) begin
                r_a <= r_a + dx;
                r_b <= r_b - dy;
                r_z <= r_z + turn_atan(r_i);
            end else begin
                r_a <= r_a - dx;
                r_b <= r_b + dy;
                r_z <= r_z - turn_atan(r_i);
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mag  = (r_zero || r_a[ACC_W-1]) ? '0 : r_a[MAG_W-1:0];
    assign o_rsp.ang  = r_zero ? 32'h0 : r_z;

endmodule

@@ rtl/ring_fourier_mode_analyzer.sv @@
// Ring Fourier mode analyser top level: sample store, mode sequencer, MAC, amplitude scaling.
// Depends on rfma_pkg, rfma_divider, rfma_twiddle, rfma_polar and the defines header.
// Samples are accepted only while collecting; the ring closing item is followed by one result per mode.
// Per mode: step divide, issue of the N samples through the 32-stage twiddle pipeline and MAC,
// vectoring, amplitude divide; no input is taken while modes run.
// Synchronous active-low reset: fill count zero, registers to defaults.
`include "ring_fourier_mode_analyzer_defines.svh"
module ring_fourier_mode_analyzer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [5:0] mode_number, [39:6] amplitude, [55:40] phase
    output logic        m_axis_tlast    // last_mode
);
    import rfma_pkg::*;

    localparam logic [3:0] S_COLLECT   = 4'd0;
    localparam logic [3:0] S_STEP_DIV  = 4'd1;
    localparam logic [3:0] S_STEP_WAIT = 4'd2;
    localparam logic [3:0] S_ISSUE     = 4'd3;
    localparam logic [3:0] S_DRAIN     = 4'd4;
    localparam logic [3:0] S_POLAR     = 4'd5;
    localparam logic [3:0] S_MUL_LO    = 4'd6;
    localparam logic [3:0] S_MUL_HI    = 4'd7;
    localparam logic [3:0] S_AMP_DIV   = 4'd8;
    localparam logic [3:0] S_AMP_WAIT  = 4'd9;
    localparam logic [3:0] S_EMIT      = 4'd10;

    localparam int Q_W  = MAG_W - 16;
    localparam int QL_W = 23;
    localparam int QH_W = Q_W - QL_W;
    localparam int P_W  = 68;

    logic [3:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_cfg_len;
    logic [MODE_W-1:0] r_cfg_hm;
    logic [LEN_W-1:0]  r_fill, r_n, r_step, r_rs, r_r;
    logic [MODE_W-1:0] r_last, r_mode;
    logic [RING_AW-1:0] r_k;
    logic [31:0]       r_qs, r_t;

    logic [SAMPLE_W-1:0] r_mem [0:MAX_RING-1];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_iss_v, r_iss_last;
    logic [31:0]         r_iss_t;

    logic [LEN_W-1:0] n_eff;
    logic             in_acc;
    logic [LEN_W:0]   r_sum;
    logic             r_ge;
    logic             last_iss;

    assign n_eff = (r_cfg_len < RING_MIN) ? RING_MIN :
                   (r_cfg_len > RING_MAX) ? RING_MAX : r_cfg_len;
    assign s_axis_tready = r_state == S_COLLECT;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign r_sum    = {1'b0, r_r} + {1'b0, r_rs};
    assign r_ge     = r_sum >= {1'b0, r_n};
    assign last_iss = {1'b0, r_k} == (r_n - 1'b1);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= RING_DEFAULT;
            r_cfg_hm  <= MODE_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RING_LENGTH:  r_cfg_len <= i_cfg_wdata;
                REG_HIGHEST_MODE: r_cfg_hm  <= i_cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // sample store: written while collecting, read one entry per cycle while issuing
    always_ff @(posedge i_clk) begin
        if (in_acc) r_mem[r_fill[RING_AW-1:0]] <= s_axis_tdata;
        r_rd_data <= r_mem[r_k];
        r_iss_t   <= r_t;
        r_iss_last <= last_iss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iss_v <= 1'b0;
        else          r_iss_v <= r_state == S_ISSUE;
    end

    // twiddle pipeline
    t_tw_in  tw_in;
    t_tw_out tw_out;
    assign tw_in.valid  = r_iss_v;
    assign tw_in.last   = r_iss_last;
    assign tw_in.angle  = r_iss_t;
    assign tw_in.sample = r_rd_data;

    rfma_twiddle u_twiddle (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tw   (tw_in),
        .o_tw   (tw_out)
    );

    // multiply-accumulate
    logic signed [SAMPLE_W-1:0] tw_x;
    logic signed [TW_W-1:0]     tw_c, tw_s;
    logic signed [PROD_W-1:0]   r_pa, r_pb;
    logic                       r_p_v, r_p_last, r_acc_done;
    logic signed [ACC_W-1:0]    r_acc_a, r_acc_b;

    assign tw_x = tw_out.sample;
    assign tw_c = tw_out.cosv;
    assign tw_s = tw_out.sinv;

    always_ff @(posedge i_clk) begin
        r_pa     <= tw_x * tw_c;
        r_pb     <= tw_x * tw_s;
        r_p_last <= tw_out.last;
        if (r_state == S_STEP_DIV) begin
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (r_p_v) begin
            r_acc_a <= r_acc_a + ACC_W'(r_pa);
            r_acc_b <= r_acc_b + ACC_W'(r_pb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v      <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_p_v      <= tw_out.valid;
            r_acc_done <= r_p_v && r_p_last;
        end
    end

    // polar conversion
    logic     pol_start;
    t_pol_rsp pol_rsp;
    assign pol_start = (r_state == S_DRAIN) && r_acc_done;

    rfma_polar u_polar (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(pol_start),
        .i_a    (r_acc_a),
        .i_b    (r_acc_b),
        .o_rsp  (pol_rsp)
    );

    // amplitude scaling and shared divider
    logic [Q_W-1:0]         r_q;
    logic [31:0]            r_ang;
    logic [QL_W+21:0]       r_plo;
    logic [QH_W+21:0]       r_phi;
    logic [P_W-1:0]         p_sum;
    logic [AMP_W-1:0]       r_amp;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    assign p_sum = {r_phi, {QL_W{1'b0}}} + P_W'(r_plo) + (P_W'(r_n) << 19);

    always_comb begin
        div_req.start    = 1'b0;
        div_req.divisor  = r_n;
        div_req.dividend = DIV_W'(r_step) << 32;
        case (r_state)
            S_STEP_DIV: div_req.start = 1'b1;
            S_AMP_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = p_sum[P_W-1:20];
            end
            default: ;
        endcase
    end

    rfma_divider u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // output register
    logic             r_o_valid, emit_load;
    logic [55:0]      r_o_data;
    logic             r_o_last;
    logic [PHASE_W-1:0] phase_r;
    logic [31:0]      ang_rnd;

    assign ang_rnd   = r_ang + 32'h8000;
    assign phase_r   = ang_rnd[31:16];
    assign emit_load = (r_state == S_EMIT) && (!r_o_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_o_data <= {phase_r, r_amp, r_mode};
            r_o_last <= r_mode == r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)              r_o_valid <= 1'b0;
        else if (emit_load)        r_o_valid <= 1'b1;
        else if (m_axis_tready)    r_o_valid <= 1'b0;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_COLLECT:   if (in_acc && (r_fill + 1'b1) >= n_eff) n_state = S_STEP_DIV;
            S_STEP_DIV:  n_state = S_STEP_WAIT;
            S_STEP_WAIT: if (div_rsp.done) n_state = S_ISSUE;
            S_ISSUE:     if (last_iss) n_state = S_DRAIN;
            S_DRAIN:     if (r_acc_done) n_state = S_POLAR;
            S_POLAR:     if (pol_rsp.done) n_state = S_MUL_LO;
            S_MUL_LO:    n_state = S_MUL_HI;
            S_MUL_HI:    n_state = S_AMP_DIV;
            S_AMP_DIV:   n_state = S_AMP_WAIT;
            S_AMP_WAIT:  if (div_rsp.done) n_state = S_EMIT;
            S_EMIT:      if (emit_load) n_state = (r_mode == r_last) ? S_COLLECT : S_STEP_DIV;
            default:     n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) r_fill <= ((r_fill + 1'b1) >= n_eff) ? '0 : r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_COLLECT: begin
                r_n    <= n_eff;
                r_last <= r_cfg_hm;
                r_mode <= '0;
                r_step <= '0;
            end
            S_STEP_WAIT: begin
                r_qs <= div_rsp.quot[31:0];
                r_rs <= div_rsp.rem;
                r_t  <= '0;
                r_r  <= '0;
                r_k  <= '0;
            end
            S_ISSUE: begin
                // angle of the next sample: floor(j * step * 2^32 / N), carried as quotient and remainder
                r_t <= r_t + r_qs + 32'(r_ge);
                r_r <= r_ge ? LEN_W'(r_sum - {1'b0, r_n}) : r_sum[LEN_W-1:0];
                r_k <= r_k + 1'b1;
            end
            S_POLAR: begin
                r_q   <= pol_rsp.mag[MAG_W-1:16];
                r_ang <= pol_rsp.ang;
            end
            S_MUL_LO: r_plo <= (QL_W+22)'(r_q[QL_W-1:0]) * (QL_W+22)'(AMP_GAIN);
            S_MUL_HI: r_phi <= (QH_W+22)'(r_q[Q_W-1:QL_W]) * (QH_W+22)'(AMP_GAIN);
            S_AMP_WAIT: begin
                r_amp <= (|div_rsp.quot[DIV_W-1:AMP_W]) ? AMP_MAX : div_rsp.quot[AMP_W-1:0];
            end
            S_EMIT: begin
                if (emit_load) begin
                    r_mode <= r_mode + 1'b1;
                    r_step <= ((r_step + 1'b1) == r_n) ? '0 : r_step + 1'b1;
                end
            end
            default: ;
        endcase
    end

    `RFMA_ASSERT_IMPLY(a_acc_in_drain, i_clk, i_rst_n, r_acc_done, r_state == S_DRAIN)
    `RFMA_ASSERT_IMPLY(a_pol_in_wait, i_clk, i_rst_n, pol_rsp.done, r_state == S_POLAR)
    `RFMA_ASSERT_IMPLY(a_div_in_wait, i_clk, i_rst_n, div_rsp.done, (r_state == S_STEP_WAIT) || (r_state == S_AMP_WAIT))
    `RFMA_ASSERT_NEXT(a_no_input_busy, i_clk, i_rst_n, pol_start, !s_axis_tready)

endmodule
